>>> sv/rasc_pkg.sv
package rasc_pkg;

  localparam int ErrW     = 16;
  localparam int SpdW     = 8;
  localparam int ModeW    = 3;
  localparam int CfgW     = 7;
  localparam int CfgIdxW  = 2;
  localparam int PcW      = 4;
  localparam int ThrW     = 17;
  localparam int SqW      = 14;
  localparam int ProdW    = 21;
  localparam int DivW     = 24;
  localparam int DivBits  = 4;
  localparam int DivSteps = DivW / DivBits;
  localparam int DivCntW  = 3;

  localparam logic [CfgW-1:0] DivisorThree     = 7'd3;
  localparam logic [CfgW-1:0] DivisorThirtyOne = 7'd31;

  localparam logic [1:0] ModeGentle = 2'd1;
  localparam logic [1:0] ModeNormal = 2'd2;
  localparam logic [1:0] ModeSteep  = 2'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RAMP_STEP    = 2'd0,
    CFG_RAMP_DIVIDER = 2'd1,
    CFG_MAX_SPEED    = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_NOP,
    OP_SQUARE,
    OP_SCALE,
    OP_DIV_A,
    OP_DIV_B,
    OP_DIV_C,
    OP_DECIDE,
    OP_TICK,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_NO_ITEM,
    COND_DIV_BUSY,
    COND_TICKS_MORE,
    COND_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t            op;
    cond_t          cond;
    logic [PcW-1:0] jump;
    logic [PcW-1:0] next;
  } ctrl_word_t;

  // jump is taken when the condition holds, otherwise next
  function automatic ctrl_word_t rom_word(input logic [PcW-1:0] pc);
    ctrl_word_t w;
    case (pc)
      4'd0:    w = '{OP_IDLE,   COND_NO_ITEM,    4'd0,  4'd1};
      4'd1:    w = '{OP_SQUARE, COND_NONE,       4'd0,  4'd2};
      4'd2:    w = '{OP_SCALE,  COND_NONE,       4'd0,  4'd3};
      4'd3:    w = '{OP_DIV_A,  COND_NONE,       4'd0,  4'd4};
      4'd4:    w = '{OP_NOP,    COND_DIV_BUSY,   4'd4,  4'd5};
      4'd5:    w = '{OP_DIV_B,  COND_NONE,       4'd0,  4'd6};
      4'd6:    w = '{OP_NOP,    COND_DIV_BUSY,   4'd6,  4'd7};
      4'd7:    w = '{OP_DIV_C,  COND_NONE,       4'd0,  4'd8};
      4'd8:    w = '{OP_NOP,    COND_DIV_BUSY,   4'd8,  4'd9};
      4'd9:    w = '{OP_DECIDE, COND_NONE,       4'd0,  4'd10};
      4'd10:   w = '{OP_TICK,   COND_TICKS_MORE, 4'd10, 4'd11};
      4'd11:   w = '{OP_EMIT,   COND_OUT_FULL,   4'd11, 4'd0};
      default: w = '{OP_IDLE,   COND_NONE,       4'd0,  4'd0};
    endcase
    return w;
  endfunction

endpackage

>>> sv/rasc_ifs.sv
interface rasc_req_if;
  logic                                valid;
  logic                                ready;
  logic signed [rasc_pkg::ErrW-1:0]    target_error;
  modport source (output valid, output target_error, input ready);
  modport sink (input valid, input target_error, output ready);
endinterface

interface rasc_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [rasc_pkg::SpdW-1:0]    drive_speed;
  logic signed [rasc_pkg::ModeW-1:0]   approach_mode;
  modport source (output valid, output drive_speed, output approach_mode, input ready);
  modport sink (input valid, input drive_speed, input approach_mode, output ready);
endinterface

>>> sv/rasc_div.sv
module rasc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rasc_pkg::DivW-1:0]   dividend,
  input  logic [rasc_pkg::CfgW-1:0]   divisor,
  output logic                        busy,
  output logic [rasc_pkg::DivW-1:0]   quotient
);

  logic [rasc_pkg::DivW-1:0]    work;
  logic [rasc_pkg::CfgW-1:0]    rem;
  logic [rasc_pkg::CfgW-1:0]    dsr;
  logic [rasc_pkg::DivCntW-1:0] cnt;
  logic [rasc_pkg::DivW-1:0]    work_next;
  logic [rasc_pkg::CfgW-1:0]    rem_next;

  // restoring division, DivBits quotient bits per cycle while busy
  always_comb begin
    logic [rasc_pkg::CfgW:0]   r;
    logic [rasc_pkg::DivW-1:0] w;
    r = {1'b0, rem};
    w = work;
    for (int k = 0; k < rasc_pkg::DivBits; k++) begin
      r = {r[rasc_pkg::CfgW-1:0], w[rasc_pkg::DivW-1]};
      w = {w[rasc_pkg::DivW-2:0], 1'b0};
      if (r >= {1'b0, dsr}) begin
        r = r - {1'b0, dsr};
        w[0] = 1'b1;
      end
    end
    rem_next  = r[rasc_pkg::CfgW-1:0];
    work_next = w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= rasc_pkg::DivCntW'(rasc_pkg::DivSteps);
      work <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
      cnt  <= cnt - 1'b1;
      busy <= (cnt != rasc_pkg::DivCntW'(1));
    end
  end

  assign quotient = work;

endmodule

>>> sv/ramped_approach_speed_controller_top.sv
// channel | dir | payload                       | accepted when
// req     | in  | target_error                  | req.valid && req.ready
// rsp     | out | drive_speed, approach_mode    | rsp.valid && rsp.ready
// cfg     | in  | cfg_index, cfg_data           | cfg_we
//
// a new transaction is accepted only after the previous one has left emit; each runs
// three divisions on the shared divider, each in 6 steps of 4 quotient bits
// synchronous reset clears speed, tick phase, approach mode and config to defaults
// a new transaction is taken while a result waits; the program stalls at emit until rsp frees
module ramped_approach_speed_controller_top (
  input  logic                           clk,
  input  logic                           rst,
  rasc_req_if.sink                       req,
  rasc_rsp_if.source                     rsp,
  input  logic                           cfg_we,
  input  logic [rasc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [rasc_pkg::CfgW-1:0]      cfg_data
);

  logic [rasc_pkg::CfgW-1:0] ramp_step;
  logic [rasc_pkg::CfgW-1:0] ramp_divider;
  logic [rasc_pkg::CfgW-1:0] max_speed;

  logic [rasc_pkg::PcW-1:0]          pc;
  logic [rasc_pkg::PcW-1:0]          pc_next;
  rasc_pkg::ctrl_word_t              ctrl;
  logic                              take;

  logic signed [rasc_pkg::ErrW-1:0]  err;
  logic signed [rasc_pkg::SpdW-1:0]  cur;
  logic [rasc_pkg::CfgW-1:0]         phase;
  logic signed [rasc_pkg::ModeW-1:0] appr;
  logic [rasc_pkg::SqW-1:0]          sq;
  logic [rasc_pkg::ProdW-1:0]        prod;
  logic signed [rasc_pkg::SpdW-1:0]  goal;
  logic [1:0]                        ticks;
  logic signed [rasc_pkg::ModeW-1:0] fin_mode;
  logic                              fin_clear;

  logic                              div_start;
  logic [rasc_pkg::DivW-1:0]         div_dividend;
  logic [rasc_pkg::CfgW-1:0]         div_divisor;
  logic                              div_busy;
  logic [rasc_pkg::DivW-1:0]         div_quot;

  logic [rasc_pkg::SqW-1:0]          cur_abs;
  logic [8:0]                        scale;
  logic [rasc_pkg::CfgW-1:0]         step_eff;
  logic [rasc_pkg::ThrW-1:0]         thr;
  logic                              err_neg;
  logic                              err_zero;
  logic signed [rasc_pkg::ErrW:0]    err_ext;
  logic [rasc_pkg::ThrW-1:0]         mag;
  logic [18:0]                       t3;
  logic [18:0]                       t34;
  logic [18:0]                       t54;
  logic [1:0]                        mode_old;
  logic [1:0]                        mode_new;
  logic signed [rasc_pkg::ModeW-1:0] mode_s;
  logic signed [rasc_pkg::SpdW-1:0]  max_s;

  logic [rasc_pkg::CfgW-1:0]         div_eff;
  logic [rasc_pkg::CfgW:0]           ph_inc;
  logic                              fire;
  logic [rasc_pkg::CfgW-1:0]         phase_tick;
  logic signed [9:0]                 cur_w;
  logic signed [9:0]                 goal_w;
  logic signed [9:0]                 step_w;
  logic signed [9:0]                 spd_w;
  logic signed [rasc_pkg::SpdW-1:0]  cur_tick;

  assign ctrl = rasc_pkg::rom_word(pc);

  always_comb begin
    case (ctrl.cond)
      rasc_pkg::COND_NONE:       take = 1'b0;
      rasc_pkg::COND_NO_ITEM:    take = !req.valid;
      rasc_pkg::COND_DIV_BUSY:   take = div_busy;
      rasc_pkg::COND_TICKS_MORE: take = (ticks > 2'd1);
      rasc_pkg::COND_OUT_FULL:   take = rsp.valid && !rsp.ready;
      default:                   take = 1'b0;
    endcase
    pc_next = take ? ctrl.jump : ctrl.next;
  end

  assign req.ready = (ctrl.op == rasc_pkg::OP_IDLE);

  // threshold arithmetic
  assign cur_abs  = rasc_pkg::SqW'(cur[7] ? 8'(-cur) : 8'(cur));
  assign scale    = {2'b00, ramp_divider} + {1'b0, ramp_divider, 1'b0} + 9'd1;
  assign step_eff = (ramp_step == '0) ? rasc_pkg::CfgW'(1) : ramp_step;
  assign thr      = div_quot[rasc_pkg::ThrW-1:0];

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {3'b000, prod};
    div_divisor  = rasc_pkg::DivisorThree;
    case (ctrl.op)
      rasc_pkg::OP_DIV_A: begin
        div_start = 1'b1;
      end
      rasc_pkg::OP_DIV_B: begin
        div_start    = 1'b1;
        div_dividend = div_quot;
        div_divisor  = step_eff;
      end
      rasc_pkg::OP_DIV_C: begin
        div_start    = 1'b1;
        div_dividend = {div_quot[rasc_pkg::DivW-2:0], 1'b0} + div_quot;
        div_divisor  = rasc_pkg::DivisorThirtyOne;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  rasc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  // decision inputs
  assign err_neg  = err[rasc_pkg::ErrW-1];
  assign err_zero = (err == '0);
  assign err_ext  = {err[rasc_pkg::ErrW-1], err};
  assign mag      = err_neg ? rasc_pkg::ThrW'(-err_ext) : rasc_pkg::ThrW'(err_ext);
  assign t3       = {2'b00, thr} + {1'b0, thr, 1'b0};
  assign t34      = t3 >> 2;
  assign t54      = ({2'b00, thr} + {thr, 2'b00}) >> 2;
  assign mode_old = appr[2] ? 2'(-appr) : appr[1:0];
  assign max_s    = $signed({1'b0, max_speed});

  always_comb begin
    mode_new = mode_old;
    case (mode_old)
      rasc_pkg::ModeGentle: begin
        if ({2'b00, mag} < t34) mode_new = rasc_pkg::ModeNormal;
      end
      rasc_pkg::ModeNormal: begin
        if ({2'b00, mag} > t3) mode_new = rasc_pkg::ModeGentle;
        if ({2'b00, mag} < t34) mode_new = rasc_pkg::ModeSteep;
      end
      rasc_pkg::ModeSteep: begin
        if ({2'b00, mag} > t54) mode_new = rasc_pkg::ModeNormal;
      end
      default: mode_new = mode_old;
    endcase
    mode_s = $signed({1'b0, mode_new});
  end

  // one ramp tick toward goal
  always_comb begin
    div_eff    = (ramp_divider == '0) ? rasc_pkg::CfgW'(1) : ramp_divider;
    ph_inc     = {1'b0, phase} + 1'b1;
    fire       = (ph_inc >= {1'b0, div_eff});
    phase_tick = fire ? '0 : ph_inc[rasc_pkg::CfgW-1:0];
    cur_w      = 10'(cur);
    goal_w     = 10'(goal);
    step_w     = $signed({3'b000, ramp_step});
    if (cur_w < goal_w) begin
      spd_w = fire ? cur_w + step_w : cur_w;
      if (spd_w > goal_w) spd_w = goal_w;
    end else if (cur_w > goal_w) begin
      spd_w = fire ? cur_w - step_w : cur_w;
      if (spd_w < goal_w) spd_w = goal_w;
    end else begin
      spd_w = cur_w;
    end
    cur_tick = spd_w[rasc_pkg::SpdW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= '0;
      cur          <= '0;
      phase        <= '0;
      appr         <= '0;
      ticks        <= '0;
      ramp_step    <= rasc_pkg::CfgW'(1);
      ramp_divider <= rasc_pkg::CfgW'(1);
      max_speed    <= '0;
      rsp.valid    <= 1'b0;
    end else begin
      pc <= pc_next;
      if (ctrl.op == rasc_pkg::OP_EMIT && !(rsp.valid && !rsp.ready)) rsp.valid <= 1'b1;
      else if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          rasc_pkg::CFG_RAMP_STEP:    ramp_step    <= cfg_data;
          rasc_pkg::CFG_RAMP_DIVIDER: ramp_divider <= cfg_data;
          rasc_pkg::CFG_MAX_SPEED:    max_speed    <= cfg_data;
          default: ;
        endcase
      end
      case (ctrl.op)
        rasc_pkg::OP_IDLE: begin
          if (req.valid) err <= req.target_error;
        end
        rasc_pkg::OP_SQUARE: begin
          sq <= cur_abs * cur_abs;
        end
        rasc_pkg::OP_SCALE: begin
          prod <= rasc_pkg::ProdW'(sq[rasc_pkg::SqW-1:2]) * rasc_pkg::ProdW'(scale);
        end
        rasc_pkg::OP_DECIDE: begin
          if (appr != '0) begin
            goal <= '0;
            if (err_zero || (err_neg != appr[2])) begin
              cur       <= '0;
              ticks     <= '0;
              fin_mode  <= '0;
              fin_clear <= 1'b0;
            end else begin
              ticks     <= mode_new - 2'd1;
              fin_mode  <= appr[2] ? -mode_s : mode_s;
              fin_clear <= 1'b1;
            end
          end else if (err_zero) begin
            cur       <= '0;
            ticks     <= '0;
            goal      <= '0;
            fin_mode  <= '0;
            fin_clear <= 1'b0;
          end else if (mag > thr) begin
            ticks     <= 2'd1;
            goal      <= err_neg ? max_s : -max_s;
            fin_mode  <= '0;
            fin_clear <= 1'b0;
          end else begin
            ticks     <= 2'd1;
            goal      <= '0;
            fin_mode  <= err_neg ? -$signed({1'b0, rasc_pkg::ModeNormal})
                                 : $signed({1'b0, rasc_pkg::ModeNormal});
            fin_clear <= 1'b0;
          end
        end
        rasc_pkg::OP_TICK: begin
          if (ticks != '0) begin
            cur   <= cur_tick;
            phase <= phase_tick;
            ticks <= ticks - 2'd1;
          end
        end
        rasc_pkg::OP_EMIT: begin
          if (!(rsp.valid && !rsp.ready)) begin
            appr              <= (fin_clear && cur == '0) ? '0 : fin_mode;
            rsp.drive_speed   <= cur;
            rsp.approach_mode <= (fin_clear && cur == '0) ? '0 : fin_mode;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> sv/rasc_checker.sv
module rasc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_ready,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic signed [rasc_pkg::SpdW-1:0]  drive_speed,
  input logic signed [rasc_pkg::ModeW-1:0] approach_mode
);

  logic [1:0] pending;

  // transactions taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(drive_speed) && $stable(approach_mode))
    else $error("stalled result changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("result without a pending transaction");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two transactions pending");

  a_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> drive_speed != -8'sd128 && approach_mode != -3'sd4)
    else $error("result out of range");

endmodule

bind ramped_approach_speed_controller_top rasc_checker u_rasc_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .drive_speed   (rsp.drive_speed),
  .approach_mode (rsp.approach_mode)
);
